[rtl/scp_copy_record_line_parser_defines.svh]
// Assertion macros shared by the record line parser RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SCP_COPY_RECORD_LINE_PARSER_DEFINES_SVH
`define SCP_COPY_RECORD_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/scp_pkg.sv]
// Shared constants and types for the record line parser.
// No dependencies; the parse core and the top level import it.
package scp_pkg;

  localparam int MAX_NAME_CAPACITY_DEFAULT = 256;
  localparam int CAP_W = 9;
  localparam logic [CAP_W-1:0] NAME_CAPACITY_RESET = 9'd256;

  localparam logic [7:0] CHAR_RECORD = 8'h43;  // 'C'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;  // '7'
  localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CHAR_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CHAR_NL     = 8'h0a;  // newline
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  // Per-byte result, apart from the name length whose width follows a parameter.
  typedef struct packed {
    logic        name_byte_valid;
    logic [7:0]  name_byte;
    logic        record_end;
    logic        accepted;
    logic [31:0] file_mode;
    logic [63:0] file_size;
  } scp_result_t;

endpackage

[rtl/scp_parse_core.sv]
// Parse state machine and per-byte result logic for the record line parser.
// Depends on scp_pkg; the state advances once per step pulse.
module scp_parse_core #(
  parameter int MAX_NAME_CAPACITY = scp_pkg::MAX_NAME_CAPACITY_DEFAULT,
  localparam int NAME_LEN_W = $clog2(MAX_NAME_CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                line_byte,
  input  logic                      last_byte,
  input  logic [scp_pkg::CAP_W-1:0] name_capacity,
  output scp_pkg::scp_result_t      result,
  output logic [NAME_LEN_W-1:0]     name_length
);
  import scp_pkg::*;

  localparam int CMP_W = (NAME_LEN_W > CAP_W) ? NAME_LEN_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_NAME_CAPACITY);
  localparam logic [NAME_LEN_W-1:0] MAX_CNT = NAME_LEN_W'(MAX_NAME_CAPACITY);

  typedef enum logic [4:0] {
    PH_LETTER = 5'b00001,
    PH_MODE   = 5'b00010,
    PH_SIZE   = 5'b00100,
    PH_NAME   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  phase_t                phase, phase_next;
  logic [31:0]           mode_acc, mode_acc_next;
  logic [63:0]           size_acc, size_acc_next;
  logic                  digit_seen, digit_seen_next;
  logic [NAME_LEN_W-1:0] name_count, name_count_next;
  logic                  failed, failed_next;
  logic                  name_valid;
  logic                  is_octal, is_decimal, ok;
  logic [CMP_W-1:0]      cap_ext, cap_eff, count_ext;

  assign is_octal   = (line_byte >= CHAR_ZERO) && (line_byte <= CHAR_SEVEN);
  assign is_decimal = (line_byte >= CHAR_ZERO) && (line_byte <= CHAR_NINE);

  always_comb begin
    phase_next      = phase;
    mode_acc_next   = mode_acc;
    size_acc_next   = size_acc;
    digit_seen_next = digit_seen;
    name_count_next = name_count;
    failed_next     = failed;
    name_valid      = 1'b0;
    unique case (phase)
      PH_LETTER: begin
        if (line_byte == CHAR_RECORD) begin
          phase_next      = PH_MODE;
          digit_seen_next = 1'b0;
        end else begin
          failed_next = 1'b1;
          phase_next  = PH_DONE;
        end
      end
      PH_MODE: begin
        if (is_octal) begin
          mode_acc_next   = {mode_acc[28:0], line_byte[2:0]};
          digit_seen_next = 1'b1;
        end else if (line_byte == CHAR_SPACE && digit_seen) begin
          phase_next      = PH_SIZE;
          digit_seen_next = 1'b0;
        end else begin
          failed_next = 1'b1;
          phase_next  = PH_DONE;
        end
      end
      PH_SIZE: begin
        if (is_decimal) begin
          // Times ten as (x << 3) + (x << 1), plus the digit value.
          size_acc_next   = {size_acc[60:0], 3'b000} + {size_acc[62:0], 1'b0}
                          + 64'(line_byte[3:0]);
          digit_seen_next = 1'b1;
        end else if (line_byte == CHAR_SPACE && digit_seen) begin
          phase_next      = PH_NAME;
          digit_seen_next = 1'b0;
        end else begin
          failed_next = 1'b1;
          phase_next  = PH_DONE;
        end
      end
      PH_NAME: begin
        if (line_byte == CHAR_NL || line_byte == CHAR_NUL) begin
          phase_next = PH_DONE;
        end else begin
          name_valid = 1'b1;
          if (name_count < MAX_CNT) begin
            name_count_next = name_count + 1'b1;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // Capacities above the maximum act as the maximum.
  assign cap_ext   = CMP_W'(name_capacity);
  assign cap_eff   = (cap_ext > MAX_CMP) ? MAX_CMP : cap_ext;
  assign count_ext = CMP_W'(name_count_next);
  assign ok = !failed_next && (phase_next == PH_NAME || phase_next == PH_DONE) &&
              (name_count_next != '0) && (count_ext < cap_eff);

  always_comb begin
    result.name_byte_valid = name_valid;
    result.name_byte       = name_valid ? line_byte : 8'h00;
    result.record_end      = last_byte;
    result.accepted        = last_byte && ok;
    result.file_mode       = last_byte ? mode_acc_next : 32'h0;
    result.file_size       = last_byte ? size_acc_next : 64'h0;
    name_length            = name_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LETTER;
      mode_acc   <= '0;
      size_acc   <= '0;
      digit_seen <= 1'b0;
      name_count <= '0;
      failed     <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        phase      <= PH_LETTER;
        mode_acc   <= '0;
        size_acc   <= '0;
        digit_seen <= 1'b0;
        name_count <= '0;
        failed     <= 1'b0;
      end else begin
        phase      <= phase_next;
        mode_acc   <= mode_acc_next;
        size_acc   <= size_acc_next;
        digit_seen <= digit_seen_next;
        name_count <= name_count_next;
        failed     <= failed_next;
      end
    end
  end

endmodule

[rtl/scp_copy_record_line_parser.sv]
// Top level of the file-copy record line parser: handshake registers and config.
// Depends on scp_pkg, scp_parse_core and scp_copy_record_line_parser_defines.svh.
//
// The block parses a record line of the form "C<octal mode> <decimal size> <name>",
// one byte per request, and returns one result per byte. Name bytes come out as they
// arrive with name_byte_valid set; a consumer should hold them until the result that
// carries record_end, and drop them unless accepted is set there. At record_end the
// result also carries the octal mode (wrapping at 32 bits), the decimal size (wrapping
// at 64 bits) and the saturating name length; the parser then starts a new record.
// A record is accepted only if the syntax was correct, the name phase was reached, and
// the name length is at least one and below name_capacity (values above
// MAX_NAME_CAPACITY act as MAX_NAME_CAPACITY; zero rejects everything). Throughput is
// one byte per cycle while out_ready stays high; each byte passes through the input
// register and then the result register. The input register and the result register
// each hold one request, so the input side can still accept one byte while a
// finished result waits for out_ready. Write name_capacity only while idle.
module scp_copy_record_line_parser #(
  parameter int MAX_NAME_CAPACITY = scp_pkg::MAX_NAME_CAPACITY_DEFAULT,
  localparam int NAME_LEN_W = $clog2(MAX_NAME_CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                line_byte,
  input  logic                      last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      name_byte_valid,
  output logic [7:0]                name_byte,
  output logic                      record_end,
  output logic                      accepted,
  output logic [31:0]               file_mode,
  output logic [63:0]               file_size,
  output logic [NAME_LEN_W-1:0]     name_length,
  input  logic                      cfg_write_enable,
  input  logic [scp_pkg::CAP_W-1:0] cfg_write_data
);
  import scp_pkg::*;
  `include "scp_copy_record_line_parser_defines.svh"

  logic                  in_q_valid;
  logic [7:0]            in_q_byte;
  logic                  in_q_last;
  logic                  advance;
  logic                  step;
  logic [CAP_W-1:0]      name_capacity;
  scp_result_t           core_result;
  logic [NAME_LEN_W-1:0] core_name_length;
  scp_result_t           res_q;
  logic [NAME_LEN_W-1:0] res_name_length;

  // The result register can take a new value when empty or being drained.
  assign advance  = !out_valid || out_ready;
  assign step     = in_q_valid && advance;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_capacity <= NAME_CAPACITY_RESET;
    end else if (cfg_write_enable) begin
      name_capacity <= cfg_write_data;
    end
  end

  // Input register: holds the accepted byte until the parse core consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_byte <= line_byte;
      in_q_last <= last_byte;
    end
  end

  scp_parse_core #(
    .MAX_NAME_CAPACITY(MAX_NAME_CAPACITY)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .line_byte    (in_q_byte),
    .last_byte    (in_q_last),
    .name_capacity(name_capacity),
    .result       (core_result),
    .name_length  (core_name_length)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q           <= core_result;
      res_name_length <= core_name_length;
    end
  end

  assign name_byte_valid = res_q.name_byte_valid;
  assign name_byte       = res_q.name_byte;
  assign record_end      = res_q.record_end;
  assign accepted        = res_q.accepted;
  assign file_mode       = res_q.file_mode;
  assign file_size       = res_q.file_size;
  assign name_length     = res_name_length;

  // Mode, size and acceptance only appear on the closing result of a record.
  `SCP_ASSERT_IMPLIES(a_mid_record_quiet, out_valid && !record_end, !accepted && file_mode == 32'h0 && file_size == 64'h0, "summary fields set before record end")
  // A name byte has always been counted.
  `SCP_ASSERT_IMPLIES(a_name_counted, out_valid && name_byte_valid, name_length != '0, "name byte without a name count")
  // An accepted record reaches the result register with a nonzero name length.
  `SCP_ASSERT_NEXT(a_accept_nonempty, step && core_result.accepted, out_valid && accepted && name_length != '0, "accepted record has an empty name")

endmodule
